// ----- rtl/sptw_pkg.sv -----
// Shared types and constants for the sampling phase tuning window.
`timescale 1ns / 1ps

package sptw_pkg;

  localparam int unsigned MAX_PHASES = 16;
  localparam int unsigned PHASE_W = $clog2(MAX_PHASES);
  localparam int unsigned COUNT_W = 5;

  localparam logic [COUNT_W-1:0] PHASE_COUNT_RESET = COUNT_W'(MAX_PHASES);
  localparam logic [1:0] RETRY_LOAD = 2'd3;

  typedef enum logic [1:0] {
    STATUS_SELECTED = 2'd0,
    STATUS_RETRY    = 2'd1,
    STATUS_NO_GOOD  = 2'd2,
    STATUS_TOO_MANY = 2'd3
  } status_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_index;
    logic               trial_pass;
    logic               request_start;
    logic               sweep_end;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [PHASE_W-1:0] chosen_phase;
  } result_t;

endpackage

// ----- rtl/sptw_track.sv -----
// Run tracking, sticky failure mask, phase selection: one trial per fire cycle.
`timescale 1ns / 1ps

module sptw_track (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  sptw_pkg::item_t                     item,
  input  logic [sptw_pkg::COUNT_W-1:0]        phase_count,
  output sptw_pkg::result_t                   result
);

  typedef struct packed {
    logic                                has_last;
    logic [sptw_pkg::PHASE_W-1:0]        last_good;
    logic [sptw_pkg::PHASE_W-1:0]        run_begin;
    logic [sptw_pkg::COUNT_W-1:0]        run_length;
    logic [sptw_pkg::PHASE_W-1:0]        best_begin;
    logic [sptw_pkg::COUNT_W-1:0]        best_length;
    logic [sptw_pkg::COUNT_W-1:0]        runs_seen;
  } sweep_t;

  localparam sweep_t SWEEP_CLEAR = '0;
  localparam logic [sptw_pkg::COUNT_W-1:0] SAT = '1;

  function automatic sweep_t close_run(input sweep_t s);
    sweep_t r;
    r = s;
    if (s.run_length != '0) begin
      if (s.run_length > s.best_length) begin
        r.best_length = s.run_length;
        r.best_begin  = s.run_begin;
      end
      if (s.runs_seen != SAT) begin
        r.runs_seen = s.runs_seen + 1'b1;
      end
      r.run_length = '0;
    end
    return r;
  endfunction

  sweep_t                              sweep;
  sweep_t                              sweep_next;
  logic [sptw_pkg::MAX_PHASES-1:0]     failed_mask;
  logic [sptw_pkg::MAX_PHASES-1:0]     failed_mask_next;
  logic [1:0]                          retries_left;
  logic [1:0]                          retries_left_next;

  sweep_t                              sw_start;
  sweep_t                              sw_upd;
  sweep_t                              sw_end;
  logic [1:0]                          retries_start;
  logic [1:0]                          retries_dec;
  logic                                in_range;
  logic                                good;
  logic                                extend;

  always_comb begin
    sw_start      = item.request_start ? SWEEP_CLEAR : sweep;
    retries_start = item.request_start ? sptw_pkg::RETRY_LOAD : retries_left;

    in_range = {1'b0, item.phase_index} < phase_count;
    good     = in_range && item.trial_pass && !failed_mask[item.phase_index];

    failed_mask_next = failed_mask;
    if (in_range && !good) begin
      failed_mask_next[item.phase_index] = 1'b1;
    end

    extend = sw_start.has_last
          && (({1'b0, sw_start.last_good} + 5'd1) == {1'b0, item.phase_index})
          && (sw_start.run_length != '0);

    sw_upd = sw_start;
    if (good) begin
      if (extend) begin
        if (sw_start.run_length != SAT) begin
          sw_upd.run_length = sw_start.run_length + 1'b1;
        end
      end else begin
        sw_upd            = close_run(sw_start);
        sw_upd.run_begin  = item.phase_index;
        sw_upd.run_length = sptw_pkg::COUNT_W'(1);
      end
      sw_upd.has_last  = 1'b1;
      sw_upd.last_good = item.phase_index;
    end

    sw_end      = close_run(sw_upd);
    retries_dec = (retries_start != 2'd0) ? retries_start - 2'd1 : 2'd0;

    result.status       = sptw_pkg::STATUS_SELECTED;
    result.chosen_phase = '0;
    if (sw_end.runs_seen == '0) begin
      result.status = (retries_dec != 2'd0) ? sptw_pkg::STATUS_RETRY
                                            : sptw_pkg::STATUS_NO_GOOD;
    end else if (sw_end.runs_seen >= phase_count) begin
      result.status = sptw_pkg::STATUS_TOO_MANY;
    end else begin
      result.chosen_phase = sw_end.best_begin + sw_end.best_length[sptw_pkg::COUNT_W-1:1];
    end

    if (item.sweep_end) begin
      sweep_next        = SWEEP_CLEAR;
      retries_left_next = (sw_end.runs_seen == '0) ? retries_dec : retries_start;
    end else begin
      sweep_next        = sw_upd;
      retries_left_next = retries_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep        <= SWEEP_CLEAR;
      failed_mask  <= '0;
      retries_left <= sptw_pkg::RETRY_LOAD;
    end else if (fire) begin
      sweep        <= sweep_next;
      failed_mask  <= failed_mask_next;
      retries_left <= retries_left_next;
    end
  end

endmodule

// ----- rtl/sample_phase_tuning_window.sv -----
// Top level of the sampling phase tuning window with its stream ports.
`timescale 1ns / 1ps

// The block takes one tuning trial per transfer on the slave stream: the phase
// tried and whether the read was good, with request_start in tuser and the
// last phase of a sweep marked by tlast. Only the transfer that carries tlast
// produces a result on the master stream: the status in tuser and the chosen
// phase in tdata, which is zero unless a phase was selected.
// A trial is held in an input register until it fires; then the run registers
// and the sticky failure mask update and any result lands in the output
// register, from which it transfers once the receiver takes it.
// One trial is accepted every cycle while the output is free to move; the
// rate is set by the run registers, which update as each trial fires.
// Reset clears the failure mask, the run registers and the valid flags of
// both stream registers, reloads three retries and sets phase_count to sixteen.
// When the receiver stalls with a result pending, trials without tlast still
// flow through, and a trial with tlast waits in the input register until the
// output frees up. phase_count is written through phase_count_we only while
// the block is idle; the user must keep to this, as the block does not enforce it.
module sample_phase_tuning_window (
  input  logic       clk,
  input  logic       rst,
  input  logic       phase_count_we,
  input  logic [4:0] phase_count_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [3:0] phase_index, [4] trial_pass, [7:5] zero
  input  logic [0:0] s_axis_tuser,   // [0] request_start
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] chosen_phase, [7:4] zero
  output logic [1:0] m_axis_tuser    // [1:0] status
);

  logic [sptw_pkg::COUNT_W-1:0] phase_count;
  logic                         s1_valid;
  sptw_pkg::item_t              s1_item;
  logic                         s1_fire;
  logic                         out_space;
  sptw_pkg::result_t            result;
  sptw_pkg::result_t            out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= sptw_pkg::PHASE_COUNT_RESET;
    end else if (phase_count_we) begin
      phase_count <= phase_count_wdata;
    end
  end

  assign out_space     = !m_axis_tvalid || m_axis_tready;
  assign s1_fire       = s1_valid && (!s1_item.sweep_end || out_space);
  assign s_axis_tready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_item.phase_index   <= s_axis_tdata[3:0];
      s1_item.trial_pass    <= s_axis_tdata[4];
      s1_item.request_start <= s_axis_tuser[0];
      s1_item.sweep_end     <= s_axis_tlast;
    end
  end

  sptw_track u_track (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .item        (s1_item),
    .phase_count (phase_count),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_fire && s1_item.sweep_end) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.sweep_end) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {4'b0000, out_result.chosen_phase};
  assign m_axis_tuser = out_result.status;

  a_chosen_zero_unless_selected : assert property (
    @(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != sptw_pkg::STATUS_SELECTED) |-> m_axis_tdata == 8'd0
  ) else $error("chosen phase is nonzero on a result that selected no phase");

  a_sweep_end_gives_result : assert property (
    @(posedge clk) disable iff (rst)
    s1_fire && s1_item.sweep_end |=> m_axis_tvalid
  ) else $error("end of sweep did not produce a result");

  a_accept_fills_stage : assert property (
    @(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> s1_valid
  ) else $error("accepted trial was lost before the input register");

  a_no_overwrite_pending : assert property (
    @(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !(s1_fire && s1_item.sweep_end)
  ) else $error("pending result would be overwritten");

endmodule
